/* rtl/bht_pkg.sv */
// Shared constants and types for the bucketed hash table.
package bht_pkg;

  localparam int MaxBuckets = 64;
  localparam int MaxWays    = 16;
  localparam int SlotTotal  = MaxBuckets * MaxWays;
  localparam int BucketW    = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int WayW       = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int SlotW      = $clog2(SlotTotal);
  localparam int BcfgW      = 7;
  localparam int WcfgW      = 5;
  localparam int CountW     = 11;
  localparam int HashSteps  = 7;
  localparam logic [31:0] HashMul = 32'h045d9f3b;

  typedef enum logic [1:0] {
    ACT_PUT = 2'd0,
    ACT_GET = 2'd1,
    ACT_DEL = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOTFND = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_BUCKETS = 1'd0,
    CFG_WAYS    = 1'd1
  } cfg_index_t;

  // Control from the sequencer to the hash unit.
  typedef struct packed {
    logic start;
    logic [31:0] key;
    logic [BcfgW-1:0] buckets;
  } hash_req_t;

  // Hash unit status back to the sequencer.
  typedef struct packed {
    logic done;
    logic [BucketW-1:0] bucket;
  } hash_rsp_t;

endpackage

/* rtl/bht_ram.sv */
// Generic single-port RAM with registered read.
module bht_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write when enabled, read registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/bht_hash.sv */
// Iterative hash unit: one shared multiplier, then a shift-subtract modulo.
module bht_hash (
  input  logic               clk,
  input  logic               rst,
  input  bht_pkg::hash_req_t req,
  output bht_pkg::hash_rsp_t rsp
);
  import bht_pkg::*;

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_MOD  = 4'b0100,
    H_DONE = 4'b1000
  } hstate_t;

  hstate_t state;
  logic [31:0] x;
  logic [1:0] round;
  logic [5:0] bitpos;
  logic [BcfgW-1:0] divisor;
  logic [BcfgW:0] rem;
  logic [31:0] mixed;
  logic [31:0] prod;
  logic [BcfgW:0] rem_shift;

  // Only the low word of the product is kept, so a 32 by 32 multiplier serves.
  assign mixed = x ^ (x >> 16);
  assign prod  = mixed * HashMul;
  assign rem_shift = {rem[BcfgW-1:0], x[5'(bitpos)]};

  // Two multiply rounds and a final xor-shift, then one remainder bit per cycle from the msb down.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      round <= '0;
      bitpos <= '0;
    end else begin
      unique case (state)
        H_IDLE: begin
          if (req.start) begin
            x <= req.key;
            round <= '0;
            if (req.buckets == '0) begin
              divisor <= BcfgW'(1);
            end else if (req.buckets > BcfgW'(MaxBuckets)) begin
              divisor <= BcfgW'(MaxBuckets);
            end else begin
              divisor <= req.buckets;
            end
            state <= H_MUL;
          end
        end
        H_MUL: begin
          if (round == 2'd2) begin
            x <= mixed;
            rem <= '0;
            bitpos <= 6'd31;
            state <= H_MOD;
          end else begin
            x <= prod;
            round <= round + 2'd1;
          end
        end
        H_MOD: begin
          if (rem_shift >= {1'b0, divisor}) begin
            rem <= rem_shift - {1'b0, divisor};
          end else begin
            rem <= rem_shift;
          end
          if (bitpos == '0) begin
            state <= H_DONE;
          end else begin
            bitpos <= bitpos - 6'd1;
          end
        end
        H_DONE: state <= H_IDLE;
        default: state <= H_IDLE;
      endcase
    end
  end

  assign rsp.done   = (state == H_DONE);
  assign rsp.bucket = rem[BucketW-1:0];

endmodule

/* rtl/bucketed_hash_table_top.sv */
// Top level of the bucketed hash table: sequencer, way scan and slot memories.
// One operation is taken at a time: a new operation is accepted only in the idle state,
// and busy stays high from acceptance until the result. After reset a clearing pass
// over all 1024 slots clears the present marks; busy is high meanwhile. Results cannot
// be stalled by the receiver.
module bucketed_hash_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] key,
  input  logic [31:0] new_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] found_value,
  output logic [10:0] entry_count
);
  import bht_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_ACT   = 7'b0100000,
    S_VAL   = 7'b1000000
  } state_t;

  state_t state;
  logic [BcfgW-1:0] buckets_in_use;
  logic [WcfgW-1:0] ways_in_use;
  logic [WcfgW-1:0] ways_live;
  logic [1:0]  op;
  logic [31:0] op_key;
  logic [31:0] op_val;
  logic [BucketW-1:0] bucket;
  logic [WayW:0] way;
  logic has_hit, has_free;
  logic [WayW-1:0] hit_way, free_way;
  logic [SlotW:0] clr_cnt;
  logic [CountW-1:0] total;
  hash_req_t hreq;
  hash_rsp_t hrsp;

  logic we_key, we_val, we_pres;
  logic [SlotW-1:0] addr;
  logic [31:0] key_rd, val_rd;
  logic [0:0] pres_rd, pres_wd;
  logic [WayW-1:0] way_sel;

  assign ways_live = (ways_in_use == '0) ? WcfgW'(1)
                   : (ways_in_use > WcfgW'(MaxWays)) ? WcfgW'(MaxWays) : ways_in_use;

  assign hreq.start   = (state == S_IDLE) && start;
  assign hreq.key     = key;
  assign hreq.buckets = buckets_in_use;

  bht_hash u_hash (.clk(clk), .rst(rst), .req(hreq), .rsp(hrsp));

  // Way addressed: scan position, or the chosen way in the action and value steps.
  always_comb begin
    if (state == S_ACT || state == S_VAL) begin
      way_sel = has_hit ? hit_way : free_way;
    end else begin
      way_sel = way[WayW-1:0];
    end
    if (state == S_CLEAR) begin
      addr = clr_cnt[SlotW-1:0];
    end else begin
      addr = SlotW'({bucket, way_sel});
    end
  end

  // Memory writes for the clearing pass and the action step.
  always_comb begin
    we_key = 1'b0;
    we_val = 1'b0;
    we_pres = 1'b0;
    pres_wd = 1'b0;
    if (state == S_CLEAR) begin
      we_pres = 1'b1;
    end else if (state == S_ACT) begin
      if (op == ACT_PUT) begin
        if (has_hit) begin
          we_val = 1'b1;
        end else if (has_free) begin
          we_key = 1'b1;
          we_val = 1'b1;
          we_pres = 1'b1;
          pres_wd = 1'b1;
        end
      end else if (op == ACT_DEL && has_hit) begin
        we_pres = 1'b1;
      end
    end
  end

  bht_ram #(.Width(32), .Depth(SlotTotal)) u_keys (
    .clk(clk), .we(we_key), .addr(addr), .wdata(op_key), .rdata(key_rd));
  bht_ram #(.Width(32), .Depth(SlotTotal)) u_vals (
    .clk(clk), .we(we_val), .addr(addr), .wdata(op_val), .rdata(val_rd));
  bht_ram #(.Width(1), .Depth(SlotTotal)) u_pres (
    .clk(clk), .we(we_pres), .addr(addr), .wdata(pres_wd), .rdata(pres_rd));

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign entry_count = total;

  // Configuration transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      buckets_in_use <= BcfgW'(64);
      ways_in_use <= WcfgW'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUCKETS: buckets_in_use <= cfg_data[BcfgW-1:0];
        CFG_WAYS:    ways_in_use <= cfg_data[WcfgW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clear, hash, scan the ways, act, report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      total <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == (SlotW+1)'(SlotTotal - 1)) begin
            state <= S_IDLE;
          end
          clr_cnt <= clr_cnt + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            op <= action;
            op_key <= key;
            op_val <= new_value;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hrsp.done) begin
            bucket <= hrsp.bucket;
            way <= '0;
            has_hit <= 1'b0;
            has_free <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (pres_rd[0]) begin
            if (!has_hit && key_rd == op_key) begin
              has_hit <= 1'b1;
              hit_way <= way[WayW-1:0];
            end
          end else if (!has_free) begin
            has_free <= 1'b1;
            free_way <= way[WayW-1:0];
          end
          if ((WcfgW)'(way) + WcfgW'(1) >= ways_live) begin
            state <= S_ACT;
          end else begin
            way <= way + 1'b1;
            state <= S_READ;
          end
        end
        S_ACT: begin
          state <= S_VAL;
        end
        S_VAL: begin
          done <= 1'b1;
          found_value <= '0;
          status <= ST_OK;
          unique case (op)
            ACT_PUT: begin
              if (!has_hit && has_free) total <= total + 1'b1;
              else if (!has_hit) status <= ST_FULL;
            end
            ACT_GET: begin
              if (has_hit) found_value <= val_rd;
              else status <= ST_NOTFND;
            end
            ACT_DEL: begin
              if (has_hit) total <= total - 1'b1;
              else status <= ST_NOTFND;
            end
            default: ;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result strobe always follows the value step.
  a_done_after_val: assert property (@(posedge clk) disable iff (rst)
    state == S_VAL |=> done) else $error("missing result strobe");
  // A result strobe comes only after the sequencer has been busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work");
  // The count changes only in the value step, so at most once per operation.
  a_count: assert property (@(posedge clk) disable iff (rst)
    total != $past(total) |-> $past(state) == S_VAL) else $error("count jump");

endmodule

/* test/tb_bucketed_hash_table_top.sv */
// Self-checking testbench for the bucketed hash table top level.
module tb_bucketed_hash_table_top;
  import bht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 1050;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 120;

  // One pending operation as seen by the driver.
  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] key;
    logic [31:0] value;
  } op_t;

  // One expected response.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [10:0] count;
  } resp_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [31:0] key;
  logic [31:0] new_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [10:0] entry_count;

  bucketed_hash_table_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .key(key),
    .new_value(new_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
    .found_value(found_value), .entry_count(entry_count)
  );

  // Shadow copy of the table contents and settings.
  logic [31:0] shadow_keys [SlotTotal];
  logic [31:0] shadow_vals [SlotTotal];
  logic        shadow_live [SlotTotal];
  logic [10:0] shadow_count;
  logic [6:0]  shadow_buckets;
  logic [4:0]  shadow_ways;

  op_t   pending_ops[$];
  resp_t expected_resps[$];
  logic [31:0] key_pool[$];

  int unsigned error_count;
  int unsigned accepted_ops;
  int unsigned checked_resps;
  int unsigned full_hits;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  logic        cfg_pending;
  logic [0:0]  cfg_pending_index;
  logic [31:0] cfg_pending_data;

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Two multiply rounds and a final xor-shift of the key.
  function automatic logic [31:0] key_hash(input logic [31:0] k);
    logic [31:0] x;
    x = k;
    x = (x ^ (x >> 16)) * HashMul;
    x = (x ^ (x >> 16)) * HashMul;
    return x ^ (x >> 16);
  endfunction

  // Apply one operation to the shadow table and return the response it gives.
  function automatic resp_t table_apply(input op_t op);
    resp_t r;
    int unsigned nb, nw, base, s, hit, free_slot;
    bit has_hit, has_free;
    nb = (shadow_buckets == 0) ? 1 : (shadow_buckets > MaxBuckets) ? MaxBuckets
         : shadow_buckets;
    nw = (shadow_ways == 0) ? 1 : (shadow_ways > MaxWays) ? MaxWays : shadow_ways;
    base = (key_hash(op.key) % nb) * MaxWays;
    has_hit = 0;
    has_free = 0;
    hit = 0;
    free_slot = 0;
    r = '0;
    for (int w = 0; w < nw; w++) begin
      s = base + w;
      if (shadow_live[s]) begin
        if (!has_hit && shadow_keys[s] == op.key) begin
          has_hit = 1;
          hit = s;
        end
      end else if (!has_free) begin
        has_free = 1;
        free_slot = s;
      end
    end
    case (op.act)
      ACT_PUT: begin
        if (has_hit) shadow_vals[hit] = op.value;
        else if (has_free) begin
          shadow_keys[free_slot] = op.key;
          shadow_vals[free_slot] = op.value;
          shadow_live[free_slot] = 1'b1;
          shadow_count = shadow_count + 1'b1;
        end else r.status = ST_FULL;
      end
      ACT_GET: begin
        if (has_hit) r.value = shadow_vals[hit];
        else r.status = ST_NOTFND;
      end
      ACT_DEL: begin
        if (has_hit) begin
          shadow_live[hit] = 1'b0;
          shadow_count = shadow_count - 1'b1;
        end else r.status = ST_NOTFND;
      end
      default: ;
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got,
             want);
    error_count++;
  endtask

  // Driver: present the next queued operation, holding it until accepted.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_resps.push_back(table_apply('{action, key, new_value}));
      accepted_ops++;
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        op_t op;
        op = pending_ops.pop_front();
        action <= op.act;
        key <= op.key;
        new_value <= op.value;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_ops.size() > 0
                 && $urandom_range(99) >= send_idle_pct) begin
      op_t op;
      op = pending_ops.pop_front();
      action <= op.act;
      key <= op.key;
      new_value <= op.value;
      start <= 1'b1;
    end
  end

  // Configuration write channel.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BUCKETS) shadow_buckets = cfg_data[6:0];
      else shadow_ways = cfg_data[4:0];
      cfg_valid <= 1'b0;
      cfg_pending = 1'b0;
    end else if (cfg_pending && !cfg_valid) begin
      cfg_index <= cfg_pending_index;
      cfg_data <= cfg_pending_data;
      cfg_valid <= 1'b1;
    end
  end

  // Monitor: compare each result strobe against the oldest expectation.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && done) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 32'd0);
      end else begin
        resp_t e;
        e = expected_resps.pop_front();
        checked_resps++;
        if (status == ST_FULL) full_hits++;
        if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
        if (found_value !== e.value) report_mismatch("found_value", found_value, e.value);
        if (entry_count !== e.count) begin
          report_mismatch("entry_count", 32'(entry_count), 32'(e.count));
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Wait until every queued operation has completed.
  task automatic wait_drained();
    while (pending_ops.size() > 0 || start || expected_resps.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    wait_drained();
    cfg_pending_index = idx;
    cfg_pending_data = data;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
    @(posedge clk);
  endtask

  // Keys are mostly drawn from a small pool so that hits and full buckets occur.
  function automatic logic [31:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(99) < 80)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic queue_op(input logic [1:0] a, input logic [31:0] k, input logic [31:0] v);
    pending_ops.push_back('{a, k, v});
  endtask

  task automatic random_phase(input int n, input int pool_size);
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom());
    for (int i = 0; i < n; i++) begin
      int r;
      logic [1:0] a;
      r = $urandom_range(99);
      a = (r < 45) ? ACT_PUT : (r < 75) ? ACT_GET : (r < 97) ? ACT_DEL : 2'd3;
      queue_op(a, pick_key(), $urandom());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = ACT_PUT;
    key = '0;
    new_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BUCKETS;
    cfg_data = '0;
    cfg_pending = 1'b0;
    cfg_pending_index = CFG_BUCKETS;
    cfg_pending_data = '0;
    error_count = 0;
    accepted_ops = 0;
    checked_resps = 0;
    full_hits = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    shadow_count = '0;
    shadow_buckets = 7'd64;
    shadow_ways = 5'd16;
    for (int i = 0; i < SlotTotal; i++) begin
      shadow_live[i] = 1'b0;
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every action, the unused code, misses.
    queue_op(ACT_GET, 32'h0, 32'h0);
    queue_op(ACT_PUT, 32'h0, 32'hFFFF_FFFF);
    queue_op(ACT_PUT, 32'hFFFF_FFFF, 32'h0);
    queue_op(ACT_GET, 32'h0, 32'h1234_5678);
    queue_op(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    queue_op(ACT_PUT, 32'h0, 32'hA5A5_5A5A);
    queue_op(ACT_GET, 32'h0, 32'h0);
    queue_op(2'd3, 32'h0, 32'hFFFF_FFFF);
    queue_op(ACT_DEL, 32'h0, 32'h0);
    queue_op(ACT_DEL, 32'h0, 32'h0);
    queue_op(ACT_GET, 32'h0, 32'h0);
    queue_op(ACT_DEL, 32'hFFFF_FFFF, 32'h0);
    wait_drained();

    // One bucket, one way: first put fills the bucket, second is refused, then update.
    write_reg(CFG_BUCKETS, 32'd1);
    write_reg(CFG_WAYS, 32'd1);
    queue_op(ACT_PUT, 32'h1, 32'h11);
    queue_op(ACT_PUT, 32'h2, 32'h22);
    queue_op(ACT_PUT, 32'h1, 32'h33);
    queue_op(ACT_GET, 32'h1, 32'h0);
    // Zero and oversized settings fall back to one and the maximum.
    write_reg(CFG_BUCKETS, 32'd0);
    write_reg(CFG_WAYS, 32'd0);
    queue_op(ACT_PUT, 32'h5, 32'h55);
    queue_op(ACT_GET, 32'h1, 32'h0);
    write_reg(CFG_BUCKETS, 32'hFFFF_FFFF);
    write_reg(CFG_WAYS, 32'hFFFF_FFFF);
    queue_op(ACT_GET, 32'h1, 32'h0);
    queue_op(ACT_PUT, 32'h7, 32'h77);

    // Random phases over several settings and idling levels.
    send_idle_pct = 0;
    write_reg(CFG_BUCKETS, 32'd2);
    write_reg(CFG_WAYS, 32'd3);
    random_phase(200, 16);
    send_idle_pct = 52;
    write_reg(CFG_BUCKETS, 32'd64);
    write_reg(CFG_WAYS, 32'd16);
    random_phase(250, 60);
    send_idle_pct = 0;
    write_reg(CFG_BUCKETS, 32'd1);
    write_reg(CFG_WAYS, 32'd16);
    random_phase(200, 24);
    send_idle_pct = 35;
    write_reg(CFG_BUCKETS, 32'd7);
    write_reg(CFG_WAYS, 32'd1);
    random_phase(200, 20);
    send_idle_pct = 52;
    write_reg(CFG_BUCKETS, 32'd33);
    write_reg(CFG_WAYS, 32'd5);
    random_phase(180, 80);

    wait_drained();
    $display("Run covered %0d operations and %0d checked results (%0d full buckets)",
             accepted_ops, checked_resps, full_hits);
    $display("over several bucket and way settings and sender idling levels.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
